// ===== rtl/core/nbrs_pkg.sv =====
// ----------------------------------------------------------------------------
// nbrs_pkg
// Shared types, codes and constants of the NAND boot read sequencer.
// ----------------------------------------------------------------------------
package nbrs_pkg;

    localparam int ADDR_W = 33;

    localparam logic [11:0] PAGE_SMALL = 12'd512;
    localparam logic [11:0] PAGE_LARGE = 12'd2048;
    localparam logic [ADDR_W-1:0] BLOCK_SMALL = 33'h0_0000_4000;
    localparam logic [ADDR_W-1:0] BLOCK_LARGE = 33'h0_0002_0000;
    localparam logic [ADDR_W-1:0] ADDR_MAX = {ADDR_W{1'b1}};

    localparam logic [7:0] MARKER_GOOD    = 8'hff;
    localparam logic [7:0] SMALL_MARK_COL = 8'h05 & 8'h0f;
    localparam logic [7:0] CMD_READ0      = 8'h00;
    localparam logic [7:0] CMD_READ_OOB   = 8'h50;
    localparam logic [7:0] CMD_READ_START = 8'h30;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_READY = 2'd1;
    localparam logic [1:0] OP_DATA  = 2'd2;

    localparam logic [1:0] REG_BASE_ADDR  = 2'd0;
    localparam logic [1:0] REG_XFER_LEN   = 2'd1;
    localparam logic [1:0] REG_LARGE      = 2'd2;
    localparam logic [1:0] REG_SKIP       = 2'd3;

    localparam logic [2:0] K_SELECT     = 3'd0;
    localparam logic [2:0] K_COMMAND    = 3'd1;
    localparam logic [2:0] K_ADDRESS    = 3'd2;
    localparam logic [2:0] K_BUFFER     = 3'd3;
    localparam logic [2:0] K_DONE       = 3'd4;
    localparam logic [2:0] K_MISALIGNED = 3'd5;

    typedef enum logic [1:0] {
        PRE_NONE = 2'd0,
        PRE_MIS  = 2'd1,
        PRE_SEL  = 2'd2,
        PRE_BUF  = 2'd3
    } t_pre;

    typedef enum logic [1:0] {
        SEQ_NONE  = 2'd0,
        SEQ_DONE  = 2'd1,
        SEQ_CHECK = 2'd2,
        SEQ_READ  = 2'd3
    } t_seq;

    typedef struct packed {
        t_pre              pre;
        t_seq              seq;
        logic              page_lg;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic [31:0]       offset;
    } t_desc;

    function automatic logic [ADDR_W-1:0] sat_add(input logic [ADDR_W-1:0] a,
                                                  input logic [ADDR_W-1:0] b);
        logic [ADDR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ADDR_W] ? ADDR_MAX : s[ADDR_W-1:0];
    endfunction

endpackage

// ===== rtl/core/nbrs_front.sv =====
// ----------------------------------------------------------------------------
// nbrs_front
// Configuration registers, transfer state and classification of each input
// word into at most one descriptor of the bus and buffer words it causes.
// ----------------------------------------------------------------------------
module nbrs_front
    import nbrs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_accept,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_flash_byte,
    output logic        o_push,
    output t_desc       o_desc
);

    typedef enum logic [4:0] {
        PH_IDLE       = 5'b00001,
        PH_RDY_CHECK  = 5'b00010,
        PH_BYTE_CHECK = 5'b00100,
        PH_RDY_PAGE   = 5'b01000,
        PH_PAGE       = 5'b10000
    } t_phase;

    logic [31:0]       r_base_addr;
    logic [30:0]       r_xfer_len;
    logic              r_large_cfg, r_skip_cfg;

    t_phase            r_phase, n_phase;
    logic [ADDR_W-1:0] r_cur, n_cur, r_end, n_end;
    logic [11:0]       r_pbc, n_pbc;
    logic [31:0]       r_dest, n_dest;
    logic              r_spc, n_spc;
    logic              r_run_large, n_run_large;
    logic              r_run_skip, n_run_skip;

    logic [11:0]       page_sz;
    logic [ADDR_W-1:0] blk_sz, cur_pg, cur_blk, end_blk;
    logic [ADDR_W-1:0] nx_cur, nx_end;
    logic              nx_lg, nx_sk, do_next, misaligned;
    logic [11:0]       pbc_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_addr  <= '0;
            r_xfer_len   <= '0;
            r_large_cfg  <= 1'b1;
            r_skip_cfg   <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_BASE_ADDR:  r_base_addr  <= i_cfg_data;
                REG_XFER_LEN:   r_xfer_len   <= i_cfg_data[30:0];
                REG_LARGE:      r_large_cfg  <= i_cfg_data[0];
                REG_SKIP:       r_skip_cfg   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign page_sz = r_run_large ? PAGE_LARGE : PAGE_SMALL;
    assign blk_sz  = r_run_large ? BLOCK_LARGE : BLOCK_SMALL;
    assign cur_pg  = sat_add(r_cur, {21'd0, page_sz});
    assign cur_blk = sat_add(r_cur, blk_sz);
    assign end_blk = sat_add(r_end, blk_sz);
    assign pbc_inc = r_pbc + 12'd1;
    assign misaligned = r_large_cfg ?
        ((r_base_addr[10:0] != '0) || (r_xfer_len[10:0] != '0)) :
        ((r_base_addr[8:0] != '0) || (r_xfer_len[8:0] != '0));

    always_comb begin
        n_phase     = r_phase;
        n_cur       = r_cur;
        n_end       = r_end;
        n_pbc       = r_pbc;
        n_dest      = r_dest;
        n_spc       = r_spc;
        n_run_large = r_run_large;
        n_run_skip  = r_run_skip;
        nx_cur      = r_cur;
        nx_end      = r_end;
        nx_lg       = r_run_large;
        nx_sk       = r_run_skip;
        do_next     = 1'b0;
        o_push      = 1'b0;
        o_desc.pre     = PRE_NONE;
        o_desc.seq     = SEQ_NONE;
        o_desc.page_lg = r_run_large;
        o_desc.addr    = r_cur;
        o_desc.data    = i_flash_byte;
        o_desc.offset  = r_dest + {20'd0, r_pbc};

        unique case (i_op)
            OP_START: begin
                o_push = 1'b1;
                if (misaligned) begin
                    o_desc.pre = PRE_MIS;
                    n_phase    = PH_IDLE;
                end else begin
                    o_desc.pre  = PRE_SEL;
                    n_run_large = r_large_cfg;
                    n_run_skip  = r_skip_cfg;
                    nx_lg       = r_large_cfg;
                    nx_sk       = r_skip_cfg;
                    nx_cur      = {1'b0, r_base_addr};
                    nx_end      = {1'b0, r_base_addr} + {2'b00, r_xfer_len};
                    n_dest      = '0;
                    n_pbc       = '0;
                    n_spc       = 1'b0;
                    do_next     = 1'b1;
                end
            end
            OP_READY: begin
                if (r_phase == PH_RDY_CHECK) begin
                    n_phase = PH_BYTE_CHECK;
                end else if (r_phase == PH_RDY_PAGE) begin
                    n_phase = PH_PAGE;
                end
            end
            OP_DATA: begin
                if (r_phase == PH_BYTE_CHECK) begin
                    o_push = 1'b1;
                    if (i_flash_byte != MARKER_GOOD) begin
                        n_spc   = 1'b0;
                        nx_cur  = cur_blk;
                        nx_end  = end_blk;
                        do_next = 1'b1;
                    end else if (!r_spc) begin
                        n_spc       = 1'b1;
                        o_desc.seq  = SEQ_CHECK;
                        o_desc.addr = cur_pg;
                        n_phase     = PH_RDY_CHECK;
                    end else begin
                        n_spc      = 1'b0;
                        o_desc.seq = SEQ_READ;
                        n_pbc      = '0;
                        n_phase    = PH_RDY_PAGE;
                    end
                end else if (r_phase == PH_PAGE) begin
                    o_push     = 1'b1;
                    o_desc.pre = PRE_BUF;
                    if (pbc_inc >= page_sz) begin
                        n_pbc   = '0;
                        nx_cur  = cur_pg;
                        n_dest  = r_dest + {20'd0, page_sz};
                        do_next = 1'b1;
                    end else begin
                        n_pbc = pbc_inc;
                    end
                end
            end
            default: ;
        endcase

        if (do_next) begin
            n_cur          = nx_cur;
            n_end          = nx_end;
            o_desc.page_lg = nx_lg;
            o_desc.addr    = nx_cur;
            if (nx_cur >= nx_end) begin
                o_desc.seq = SEQ_DONE;
                n_phase    = PH_IDLE;
            end else if (nx_sk && (nx_lg ? (nx_cur[16:0] == '0) : (nx_cur[13:0] == '0))) begin
                n_spc      = 1'b0;
                o_desc.seq = SEQ_CHECK;
                n_phase    = PH_RDY_CHECK;
            end else begin
                o_desc.seq = SEQ_READ;
                n_pbc      = '0;
                n_phase    = PH_RDY_PAGE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_cur       <= '0;
            r_end       <= '0;
            r_pbc       <= '0;
            r_dest      <= '0;
            r_spc       <= 1'b0;
            r_run_large <= 1'b1;
            r_run_skip  <= 1'b1;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_cur       <= n_cur;
            r_end       <= n_end;
            r_pbc       <= n_pbc;
            r_dest      <= n_dest;
            r_spc       <= n_spc;
            r_run_large <= n_run_large;
            r_run_skip  <= n_run_skip;
        end
    end

endmodule

// ===== rtl/core/nbrs_queue.sv =====
// ----------------------------------------------------------------------------
// nbrs_queue
// Two-entry descriptor queue between the classifier and the word sequencer.
// ----------------------------------------------------------------------------
module nbrs_queue
    import nbrs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_desc o_desc
);

    t_desc      r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign o_desc  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/core/nbrs_back.sv =====
// ----------------------------------------------------------------------------
// nbrs_back
// Word sequencer: expands one descriptor into its select, command, address,
// buffer and status words, one word per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module nbrs_back
    import nbrs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_desc       i_q_desc,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_value,
    output logic [31:0] o_offset,
    output logic        o_last
);

    t_desc      r_desc;
    logic       r_busy;
    logic [2:0] r_idx;

    logic       has_pre, finish;
    logic [3:0] seq_cnt, total;
    logic [2:0] s;

    assign has_pre = r_desc.pre != PRE_NONE;

    always_comb begin
        unique case (r_desc.seq) inside
            SEQ_DONE:             seq_cnt = 4'd2;
            SEQ_CHECK, SEQ_READ:  seq_cnt = r_desc.page_lg ? 4'd7 : 4'd5;
            default:              seq_cnt = 4'd0;
        endcase
    end

    assign total       = seq_cnt + {3'd0, has_pre};
    assign o_last      = ({1'b0, r_idx} + 4'd1) == total;
    assign o_out_valid = r_busy;
    assign finish      = r_busy && !i_out_stall && o_last;
    assign o_pop       = !i_q_empty && (!r_busy || finish);
    assign s           = r_idx - {2'd0, has_pre};

    always_comb begin
        o_kind   = K_ADDRESS;
        o_value  = '0;
        o_offset = '0;
        if (has_pre && r_idx == '0) begin
            unique case (r_desc.pre)
                PRE_MIS: o_kind = K_MISALIGNED;
                PRE_SEL: o_kind = K_SELECT;
                default: begin
                    o_kind   = K_BUFFER;
                    o_value  = r_desc.data;
                    o_offset = r_desc.offset;
                end
            endcase
        end else if (r_desc.seq == SEQ_DONE) begin
            if (s == '0) begin
                o_kind  = K_SELECT;
                o_value = 8'd1;
            end else begin
                o_kind = K_DONE;
            end
        end else if (r_desc.page_lg) begin
            unique case (s)
                3'd0: begin
                    o_kind  = K_COMMAND;
                    o_value = CMD_READ0;
                end
                3'd1: o_value = '0;
                3'd2: o_value = (r_desc.seq == SEQ_CHECK) ? {4'd0, PAGE_LARGE[11:8]} : 8'h00;
                3'd3: o_value = r_desc.addr[18:11];
                3'd4: o_value = r_desc.addr[26:19];
                3'd5: o_value = {2'b00, r_desc.addr[32:27]};
                default: begin
                    o_kind  = K_COMMAND;
                    o_value = CMD_READ_START;
                end
            endcase
        end else begin
            unique case (s)
                3'd0: begin
                    o_kind  = K_COMMAND;
                    o_value = (r_desc.seq == SEQ_CHECK) ? CMD_READ_OOB : CMD_READ0;
                end
                3'd1: o_value = (r_desc.seq == SEQ_CHECK) ? SMALL_MARK_COL
                                                           : r_desc.addr[7:0];
                3'd2: o_value = r_desc.addr[16:9];
                3'd3: o_value = r_desc.addr[24:17];
                default: o_value = r_desc.addr[32:25];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_desc <= i_q_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (finish) begin
            r_busy <= 1'b0;
        end else if (r_busy && !i_out_stall) begin
            r_idx <= r_idx + 3'd1;
        end
    end

endmodule

// ===== rtl/core/nand_boot_read_sequencer.sv =====
// ----------------------------------------------------------------------------
// nand_boot_read_sequencer
// NAND page read engine with bad block skipping, top level.
// ----------------------------------------------------------------------------
// Input words (start, flash ready, flash data byte) are taken one per cycle
// while the two-entry descriptor queue has room; each is classified in the
// cycle it is accepted. Output words leave one per cycle from the word
// sequencer while the output is not stalled: a page data byte gives one
// buffer word, a page or marker read gives five (small pages) or seven
// (large pages) command and address words, a start adds one select word,
// and the finish gives two words, a select and a done word. The word
// sequencer therefore sets the output rate, up to eight words per input
// word; during a page burst the sustained rate is one word per cycle.
// Registers take effect at the next start; the configuration port is always ready.
// ----------------------------------------------------------------------------
module nand_boot_read_sequencer
    import nbrs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_flash_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_value,
    output logic [31:0] o_offset,
    output logic        o_last
);

    logic  w_accept, w_push, w_pop, w_full, w_empty;
    t_desc w_front_desc, w_q_desc;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_full;
    assign w_accept    = i_in_valid && !w_full;

    nbrs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (w_accept),
        .i_op         (i_op),
        .i_flash_byte (i_flash_byte),
        .o_push       (w_push),
        .o_desc       (w_front_desc)
    );

    nbrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push && w_accept),
        .i_desc  (w_front_desc),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_desc  (w_q_desc)
    );

    nbrs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_empty),
        .i_q_desc    (w_q_desc),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_kind      (o_kind),
        .o_value     (o_value),
        .o_offset    (o_offset),
        .o_last      (o_last)
    );

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("descriptor popped from empty queue");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == K_DONE || o_kind == K_MISALIGNED)) |-> o_last)
        else $error("done or misaligned word not marked last");

    a_buffer_offset_zero_else: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind != K_BUFFER) |-> (o_offset == '0))
        else $error("non-buffer word carries an offset");

endmodule

// ===== dv/tb_nand_boot_read_sequencer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nand_boot_read_sequencer
// Self-checking testbench for the NAND boot read sequencer. The bench plays
// the flash: it answers the block's command and address words with ready and
// marker or page bytes, and a read predictor works out every select, command,
// address, buffer, done and misaligned word the block should emit. Directed
// cases come first, then a page transfer with the output held off, random
// transfers with noise and aborts, and a run of bad blocks near the top of
// the address space. Both handshakes idle and stall at random throughout.
// ----------------------------------------------------------------------------
module tb_nand_boot_read_sequencer
    import nbrs_pkg::*;
();

    localparam int          CYCLE_LIMIT    = 200_000;
    localparam int          SETTLE_CYCLES  = 64;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          ITEM_TARGET    = 310;
    localparam int          HOLD_RUN_ITEMS = 64;
    localparam int          TAIL_ITEMS     = 24;
    localparam logic [1:0]  OP_UNUSED      = 2'd3;
    localparam logic [7:0]  SEL_ACTIVE     = 8'd0;
    localparam logic [7:0]  SEL_RELEASED   = 8'd1;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_MARK_RDY = 5'b00010,
        PH_MARK     = 5'b00100,
        PH_PAGE_RDY = 5'b01000,
        PH_PAGE     = 5'b10000
    } t_seq_phase;

    typedef enum logic [1:0] {
        DRIVE_NOISY,
        DRIVE_GOOD_MARKS,
        DRIVE_BAD_MARKS
    } t_drive_mode;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  value;
        logic [31:0] offset;
        logic        last;
    } t_flash_word;

    class t_read_scoreboard;
        logic [31:0] base_addr;
        logic [30:0] xfer_len;
        logic        large_cfg;
        logic        skip_cfg;
        t_seq_phase  phase;
        logic [32:0] cur_addr;
        logic [32:0] end_addr;
        logic [11:0] byte_cnt;
        logic [31:0] dst_off;
        logic        second_mark;
        logic        run_large;
        logic        run_skip;
        t_flash_word due_words[$];
        t_flash_word step_words[$];
        int          errors;

        function new();
            base_addr   = '0;
            xfer_len    = '0;
            large_cfg   = 1'b1;
            skip_cfg    = 1'b1;
            phase       = PH_IDLE;
            cur_addr    = '0;
            end_addr    = '0;
            byte_cnt    = '0;
            dst_off     = '0;
            second_mark = 1'b0;
            run_large   = 1'b1;
            run_skip    = 1'b1;
            errors      = 0;
        endfunction

        function int pending();
            return due_words.size();
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] d);
            case (idx)
                REG_BASE_ADDR:  base_addr = d;
                REG_XFER_LEN:   xfer_len = d[30:0];
                REG_LARGE:      large_cfg = d[0];
                REG_SKIP:       skip_cfg = d[0];
                default: ;
            endcase
        endfunction

        function logic [32:0] page_bytes();
            return run_large ? 33'(PAGE_LARGE) : 33'(PAGE_SMALL);
        endfunction

        function logic [32:0] block_bytes();
            return run_large ? BLOCK_LARGE : BLOCK_SMALL;
        endfunction

        function logic [32:0] clamp_add(logic [32:0] a, logic [32:0] b);
            logic [33:0] s;
            s = 34'(a) + 34'(b);
            return (s > 34'(ADDR_MAX)) ? ADDR_MAX : s[32:0];
        endfunction

        function void put(logic [2:0] kind, logic [7:0] value, logic [31:0] off);
            t_flash_word w;
            w.kind   = kind;
            w.value  = value;
            w.offset = off;
            w.last   = 1'b0;
            step_words.push_back(w);
        endfunction

        function void send_addr(logic [32:0] a, logic [11:0] col);
            logic [32:0] pg_no;
            pg_no = a >> 11;
            put(K_ADDRESS, col[7:0], '0);
            if (run_large) begin
                put(K_ADDRESS, {4'b0, col[11:8]}, '0);
                put(K_ADDRESS, pg_no[7:0], '0);
                put(K_ADDRESS, pg_no[15:8], '0);
                put(K_ADDRESS, pg_no[23:16], '0);
            end else begin
                put(K_ADDRESS, a[16:9], '0);
                put(K_ADDRESS, a[24:17], '0);
                put(K_ADDRESS, a[32:25], '0);
            end
        endfunction

        function void mark_read(logic [32:0] a);
            if (run_large) begin
                put(K_COMMAND, CMD_READ0, '0);
                send_addr(a, PAGE_LARGE);
                put(K_COMMAND, CMD_READ_START, '0);
            end else begin
                put(K_COMMAND, CMD_READ_OOB, '0);
                send_addr(a, {4'b0, SMALL_MARK_COL});
            end
            phase = PH_MARK_RDY;
        endfunction

        function void page_read(logic [32:0] a);
            put(K_COMMAND, CMD_READ0, '0);
            send_addr(a, run_large ? 12'd0 : {4'b0, a[7:0]});
            if (run_large) put(K_COMMAND, CMD_READ_START, '0);
            byte_cnt = '0;
            phase = PH_PAGE_RDY;
        endfunction

        function void next_step();
            if (cur_addr >= end_addr) begin
                put(K_SELECT, SEL_RELEASED, '0);
                put(K_DONE, 8'd0, '0);
                phase = PH_IDLE;
            end else if (run_skip && (cur_addr & (block_bytes() - 33'd1)) == '0) begin
                second_mark = 1'b0;
                mark_read(cur_addr);
            end else begin
                page_read(cur_addr);
            end
        endfunction

        function int take_input(logic [1:0] op, logic [7:0] b);
            logic [31:0] mask;
            t_flash_word w;
            step_words.delete();
            case (op)
                OP_START: begin
                    mask = (large_cfg ? 32'(PAGE_LARGE) : 32'(PAGE_SMALL)) - 32'd1;
                    if ((base_addr & mask) != '0 || ({1'b0, xfer_len} & mask) != '0) begin
                        put(K_MISALIGNED, 8'd0, '0);
                        phase = PH_IDLE;
                    end else begin
                        run_large   = large_cfg;
                        run_skip    = skip_cfg;
                        cur_addr    = 33'(base_addr);
                        end_addr    = 33'(base_addr) + 33'(xfer_len);
                        dst_off     = '0;
                        byte_cnt    = '0;
                        second_mark = 1'b0;
                        put(K_SELECT, SEL_ACTIVE, '0);
                        next_step();
                    end
                end
                OP_READY: begin
                    if (phase == PH_MARK_RDY) phase = PH_MARK;
                    else if (phase == PH_PAGE_RDY) phase = PH_PAGE;
                end
                OP_DATA: begin
                    if (phase == PH_MARK) begin
                        if (b != MARKER_GOOD) begin
                            second_mark = 1'b0;
                            cur_addr = clamp_add(cur_addr, block_bytes());
                            end_addr = clamp_add(end_addr, block_bytes());
                            next_step();
                        end else if (!second_mark) begin
                            second_mark = 1'b1;
                            mark_read(clamp_add(cur_addr, page_bytes()));
                        end else begin
                            second_mark = 1'b0;
                            page_read(cur_addr);
                        end
                    end else if (phase == PH_PAGE) begin
                        put(K_BUFFER, b, dst_off + 32'(byte_cnt));
                        byte_cnt++;
                        if (33'(byte_cnt) >= page_bytes()) begin
                            byte_cnt = '0;
                            cur_addr = clamp_add(cur_addr, page_bytes());
                            dst_off  = dst_off + 32'(page_bytes());
                            next_step();
                        end
                    end
                end
                default: ;
            endcase
            foreach (step_words[i]) begin
                w = step_words[i];
                w.last = (i == step_words.size() - 1);
                due_words.push_back(w);
            end
            return step_words.size();
        endfunction

        function void match_word(logic [2:0] kind, logic [7:0] value, logic [31:0] off,
                                 logic last);
            t_flash_word want;
            if (due_words.size() == 0) begin
                errors++;
                $display("%0t: unexpected word: kind %0d value %02h offset %08h last %0d",
                         $time, kind, value, off, last);
                return;
            end
            want = due_words.pop_front();
            if (want.kind !== kind || want.value !== value || want.offset !== off ||
                want.last !== last) begin
                errors++;
                $display("%0t: word mismatch: expected kind %0d value %02h offset %08h last %0d,",
                         $time, want.kind, want.value, want.offset, want.last,
                         " got kind %0d value %02h offset %08h last %0d",
                         kind, value, off, last);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_op;
    logic [7:0]  i_flash_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_kind;
    logic [7:0]  o_value;
    logic [31:0] o_offset;
    logic        o_last;

    t_read_scoreboard flash_seq;
    t_read_scoreboard stim_shadow;
    int               burst_left;
    int               sent_items;
    int               cycle_count;
    bit               hold_req;

    nand_boot_read_sequencer DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_flash_byte (i_flash_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kind       (o_kind),
        .o_value      (o_value),
        .o_offset     (o_offset),
        .o_last       (o_last)
    );

    always #4 i_clk = ~i_clk;

    // input words are noted before output words are checked at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                void'(flash_seq.take_input(i_op, i_flash_byte));
            if (o_out_valid && !i_out_stall)
                flash_seq.match_word(o_kind, o_value, o_offset, o_last);
        end
    end

    // receiver: segments of no, light or heavy stalling, plus one long hold
    initial begin
        int seg;
        int pct;
        i_out_stall = 1'b0;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    i_out_stall <= 1'b1;
                end
            end
            seg = $urandom_range(1, 40);
            case ($urandom_range(0, 2))
                0:       pct = 0;
                1:       pct = 25;
                default: pct = 70;
            endcase
            for (int k = 0; k < seg && !hold_req; k++) begin
                @(negedge i_clk);
                i_out_stall <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: cycle limit reached with %0d words due", $time, flash_seq.pending());
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] b);
        if (burst_left == 0) begin
            if (i_in_valid) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_flash_byte <= b;
        void'(stim_shadow.take_input(op, b));
        stim_shadow.due_words.delete();
        sent_items++;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic settle();
        if (i_in_valid) i_in_valid <= 1'b0;
        burst_left = 0;
        while (flash_seq.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [31:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        flash_seq.write_reg(idx, d);
        stim_shadow.write_reg(idx, d);
        @(negedge i_clk);
    endtask

    task automatic load_regs(input logic [31:0] sa, input logic [30:0] len,
                             input logic lg, input logic sk);
        put_reg(REG_BASE_ADDR, sa);
        put_reg(REG_XFER_LEN, {1'($urandom), len});
        put_reg(REG_LARGE, {31'($urandom), lg});
        put_reg(REG_SKIP, {31'($urandom), sk});
        i_cfg_valid <= 1'b0;
    endtask

    // plays the flash against the shadow copy of the sequencer
    task automatic pick_item(input t_drive_mode mode, output logic [1:0] op,
                             output logic [7:0] b);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        b = 8'($urandom);
        if (mode == DRIVE_NOISY && roll < 8) begin
            op = 2'($urandom);
        end else begin
            case (stim_shadow.phase) inside
                PH_IDLE:                  op = OP_START;
                PH_MARK_RDY, PH_PAGE_RDY: op = OP_READY;
                PH_MARK: begin
                    op = OP_DATA;
                    if (mode == DRIVE_BAD_MARKS) b = 8'($urandom_range(0, 254));
                    else if (mode == DRIVE_GOOD_MARKS || roll < 80) b = MARKER_GOOD;
                end
                default:                  op = OP_DATA;
            endcase
        end
    endtask

    task automatic run_transfer(input t_drive_mode mode, input bit hold_on_page,
                                input int budget);
        logic [1:0] op;
        logic [7:0] b;
        send_item(OP_START, 8'($urandom));
        while (budget != 0 && stim_shadow.phase != PH_IDLE) begin
            if (hold_on_page && stim_shadow.phase == PH_PAGE) begin
                hold_req = 1'b1;
                hold_on_page = 1'b0;
            end
            pick_item(mode, op, b);
            send_item(op, b);
            budget--;
        end
        settle();
    endtask

    task automatic run_episode();
        logic [31:0] sa;
        logic [30:0] len;
        logic        lg;
        logic        sk;
        logic [31:0] pg;
        logic [31:0] blk;
        int unsigned roll;
        int          budget;
        logic [1:0]  op;
        logic [7:0]  b;
        lg  = 1'($urandom);
        sk  = ($urandom_range(0, 99) < 70);
        pg  = lg ? 32'(PAGE_LARGE) : 32'(PAGE_SMALL);
        blk = lg ? BLOCK_LARGE[31:0] : BLOCK_SMALL[31:0];
        roll = $urandom_range(0, 99);
        if (roll < 10)      sa = '0;
        else if (roll < 20) sa = ~(pg - 32'd1);
        else if (roll < 50) sa = $urandom & ~(blk - 32'd1);
        else if (roll < 85) sa = $urandom & ~(pg - 32'd1);
        else                sa = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 10)      len = '0;
        else if (roll < 45) len = 31'(pg);
        else if (roll < 65) len = 31'(pg << 1);
        else if (roll < 85) len = 31'h7fff_ffff & ~31'(pg - 32'd1);
        else                len = 31'($urandom);
        load_regs(sa, len, lg, sk);
        budget = $urandom_range(6, 40);
        send_item(OP_START, 8'($urandom));
        while (budget != 0 && stim_shadow.phase != PH_IDLE) begin
            if ($urandom_range(0, 99) < 4) settle();
            pick_item(DRIVE_NOISY, op, b);
            send_item(op, b);
            budget--;
        end
        settle();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = REG_BASE_ADDR;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_op         = OP_START;
        i_flash_byte = '0;
        burst_left   = 0;
        sent_items   = 0;
        hold_req     = 1'b0;
        flash_seq    = new();
        stim_shadow  = new();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: zero length, then words nobody is waiting for
        send_item(OP_START, 8'h00);
        send_item(OP_READY, 8'hff);
        send_item(OP_DATA, 8'h5a);
        send_item(OP_UNUSED, 8'hff);
        settle();
        load_regs(32'h0000_0200, 31'd0, 1'b1, 1'b1);
        send_item(OP_START, 8'h00);
        settle();
        load_regs(32'hffff_ffff, 31'h7fff_ffff, 1'b0, 1'b1);
        send_item(OP_START, 8'hff);
        settle();
        // top block, bad second marker, skip into the next block, abort mid-page
        load_regs(32'hffff_c000, 31'h0000_0200, 1'b0, 1'b1);
        send_item(OP_START, 8'h00);
        send_item(OP_READY, 8'h00);
        send_item(OP_DATA, 8'hff);
        send_item(OP_READY, 8'h00);
        send_item(OP_DATA, 8'h00);
        send_item(OP_READY, 8'h00);
        send_item(OP_DATA, 8'hff);
        send_item(OP_READY, 8'h00);
        send_item(OP_DATA, 8'hff);
        send_item(OP_READY, 8'h00);
        send_item(OP_DATA, 8'h00);
        send_item(OP_DATA, 8'hff);
        send_item(OP_START, 8'h00);
        send_item(OP_READY, 8'h00);
        send_item(OP_DATA, 8'h7e);
        settle();

        // small page transfer, output held off once the page data starts
        load_regs(32'h0001_c000, 31'd1024, 1'b0, 1'b1);
        run_transfer(DRIVE_GOOD_MARKS, 1'b1, HOLD_RUN_ITEMS);

        while (sent_items < ITEM_TARGET - TAIL_ITEMS) run_episode();

        // bad blocks in a row near the top of the address space
        load_regs(32'hfffe_0000, 31'h7fff_f800, 1'b1, 1'b1);
        run_transfer(DRIVE_BAD_MARKS, 1'b0, TAIL_ITEMS);

        settle();
        if (flash_seq.errors == 0 && flash_seq.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
